// ===== rtl/cmap_pkg.sv =====
package cmap_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned NUM_STOPS   = 6;
  localparam int unsigned PIPE_DEPTH  = 14;

  typedef enum logic [2:0] {
    REG_POSITIONS = 3'd0,
    REG_COLORS_A  = 3'd1,
    REG_COLORS_B  = 3'd2,
    REG_COLORS_C  = 3'd3,
    REG_COUNT     = 3'd4,
    REG_LOW       = 3'd5,
    REG_HIGH      = 3'd6,
    REG_MODE      = 3'd7
  } cfg_reg_t;

  localparam logic [53:0] POSITIONS_RST = 54'd9022613917548544;
  localparam logic [2:0]  COUNT_RST     = 3'd6;
  localparam logic [15:0] LOW_RST       = 16'd0;
  localparam logic [15:0] HIGH_RST      = 16'hFFFF;
  localparam logic [1:0]  MODE_RST      = 2'd0;

  // even stops 0,2,4 and odd stops 1,3,5 live in separate memories
  localparam logic [23:0] EVEN_RST [3] = '{24'h000080, 24'h00FFFF, 24'hFF0000};
  localparam logic [23:0] ODD_RST  [3] = '{24'h0000FF, 24'hFFFF00, 24'h800000};

  typedef struct packed {
    logic [15:0] s;
    logic [23:0] rem;
    logic [15:0] den;
    logic [7:0]  q;
    logic        force_zero;
    logic        force_max;
    logic        raw;
    logic        oor;
  } idx_stage_t;

  typedef struct packed {
    logic [7:0] idx;
    logic       oor;
  } sel_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [8:0] lo;
    logic [8:0] hi;
    logic       copy;
    logic       black;
    logic       low_odd;
    logic [1:0] e_addr;
    logic [1:0] o_addr;
    logic       oor;
  } srch_t;

  typedef struct packed {
    logic [2:0][16:0] rem;
    logic [2:0][7:0]  q;
    logic [8:0]       den;
    logic             oor;
  } blend_t;

endpackage

// ===== rtl/gradient_colormap_pixel_unit.sv =====
// done is the taken start delayed through the valid shift register v and rises
// with the registered colors. Throughput: one sample per clock while not busy;
// the index and blend dividers are 2 bits per stage
// reset: a clearing pass writes the default stop colors into the color memories,
// busy is held high and cfg_ready low meanwhile; other config registers reset at once
// results are shown for one cycle only, the receiver cannot stall
module gradient_colormap_pixel_unit import cmap_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sample,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        out_of_range,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [53:0] cfg_data
);

  logic [53:0] stop_positions;
  logic [2:0]  stop_count;
  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [1:0]  mode_bits;

  logic [23:0] mem_even [3];
  logic [23:0] mem_odd  [3];

  logic       init_act;
  logic [1:0] init_cnt;

  logic [PIPE_DEPTH-1:0] v;
  idx_stage_t prep;
  idx_stage_t idiv [4];
  sel_t       sel;
  srch_t      srch;
  srch_t      mst;
  logic [23:0] e_rd;
  logic [23:0] o_rd;
  blend_t     bl;
  blend_t     bdiv [4];

  logic take;
  logic cfg_wr;
  cfg_reg_t cfg_reg;

  assign take      = start && !busy;
  assign busy      = init_act;
  assign cfg_ready = !init_act;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_reg   = cfg_reg_t'(cfg_index);

  function automatic idx_stage_t idx_div2(idx_stage_t a, int unsigned b);
    idx_stage_t r;
    logic [23:0] d;
    r = a;
    for (int j = 0; j < 2; j++) begin
      d = {8'd0, a.den} << (b + 1 - j);
      if (r.rem >= d) begin
        r.rem = r.rem - d;
        r.q[b + 1 - j] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic blend_t blend_div2(blend_t a, int unsigned b);
    blend_t r;
    logic [16:0] d;
    r = a;
    for (int c = 0; c < 3; c++) begin
      for (int j = 0; j < 2; j++) begin
        d = {8'd0, a.den} << (b + 1 - j);
        if (r.rem[c] >= d) begin
          r.rem[c] = r.rem[c] - d;
          r.q[c][b + 1 - j] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // config registers and clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      stop_positions <= POSITIONS_RST;
      stop_count     <= COUNT_RST;
      range_low      <= LOW_RST;
      range_high     <= HIGH_RST;
      mode_bits      <= MODE_RST;
      init_act       <= 1'b1;
      init_cnt       <= 2'd0;
    end else begin
      if (init_act) begin
        init_cnt <= init_cnt + 2'd1;
        if (init_cnt == 2'd2) init_act <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_reg)
          REG_POSITIONS: stop_positions <= cfg_data;
          REG_COUNT:     stop_count     <= cfg_data[2:0];
          REG_LOW:       range_low      <= cfg_data[15:0];
          REG_HIGH:      range_high     <= cfg_data[15:0];
          REG_MODE:      mode_bits      <= cfg_data[1:0];
          REG_COLORS_A, REG_COLORS_B, REG_COLORS_C: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init_act) begin
      mem_even[init_cnt] <= EVEN_RST[init_cnt];
      mem_odd[init_cnt]  <= ODD_RST[init_cnt];
    end else if (cfg_wr && (cfg_reg == REG_COLORS_A || cfg_reg == REG_COLORS_B ||
                            cfg_reg == REG_COLORS_C)) begin
      mem_even[cfg_index[1:0] - 2'd1] <= cfg_data[23:0];
      mem_odd[cfg_index[1:0] - 2'd1]  <= cfg_data[47:24];
    end
    e_rd <= mem_even[srch.e_addr];
    o_rd <= mem_odd[srch.o_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else     v <= {v[PIPE_DEPTH-2:0], take};
  end

  // prep: range offset times 255, overflow and limit flags
  logic [15:0] s_in;
  logic [15:0] diff;
  logic [15:0] den_in;
  always_comb begin
    s_in   = 16'(sample[SAMPLE_BITS-1:0]);
    diff   = s_in - range_low;
    den_in = range_high - range_low;
  end

  always_ff @(posedge clk) begin
    prep.s          <= s_in;
    prep.rem        <= 24'(diff * 8'd255);
    prep.den        <= den_in;
    prep.q          <= 8'd0;
    prep.force_zero <= (range_high <= range_low) || (s_in <= range_low);
    prep.force_max  <= diff >= den_in;
    prep.raw        <= !mode_bits[0];
    prep.oor        <= mode_bits[1] && ((s_in < range_low) || (s_in > range_high));
    idiv[0] <= idx_div2(prep, 6);
    idiv[1] <= idx_div2(idiv[0], 4);
    idiv[2] <= idx_div2(idiv[1], 2);
    idiv[3] <= idx_div2(idiv[2], 0);
  end

  // round half to even and pick the index source
  logic [24:0] twice_rem;
  logic        round_up;
  always_ff @(posedge clk) begin
    priority if (idiv[3].raw)
      sel.idx <= (idiv[3].s > 16'd255) ? 8'd255 : idiv[3].s[7:0];
    else if (idiv[3].force_zero)
      sel.idx <= 8'd0;
    else if (idiv[3].force_max)
      sel.idx <= 8'd255;
    else
      sel.idx <= idiv[3].q + {7'd0, round_up};
    sel.oor <= idiv[3].oor;
  end
  always_comb begin
    twice_rem = {idiv[3].rem, 1'b0};
    round_up  = (twice_rem > {9'd0, idiv[3].den}) ||
                ((twice_rem == {9'd0, idiv[3].den}) && idiv[3].q[0]);
  end

  // stop search
  logic [8:0] pos [NUM_STOPS];
  logic [2:0] n_use;
  logic [2:0] fi;
  logic [2:0] lsel;
  logic       cp;
  srch_t      srch_next;
  always_comb begin
    for (int i = 0; i < NUM_STOPS; i++) pos[i] = stop_positions[9*i +: 9];
    n_use = (stop_count > 3'(NUM_STOPS)) ? 3'(NUM_STOPS) : stop_count;
    fi = n_use;
    for (int i = NUM_STOPS - 1; i >= 0; i--) begin
      if (3'(i) < n_use && pos[i] >= {1'b0, sel.idx}) fi = 3'(i);
    end
    cp   = 1'b0;
    lsel = fi - 3'd1;
    priority if (n_use <= 3'd1 || fi == 3'd0) begin
      cp   = 1'b1;
      lsel = 3'd0;
    end else if (fi == n_use) begin
      cp   = 1'b1;
      lsel = n_use - 3'd1;
    end
    srch_next.idx     = sel.idx;
    srch_next.lo      = pos[lsel];
    srch_next.hi      = cp ? pos[lsel] : pos[lsel + 3'd1];
    srch_next.copy    = cp;
    srch_next.black   = n_use == 3'd0;
    srch_next.low_odd = lsel[0];
    srch_next.o_addr  = lsel[2:1];
    srch_next.e_addr  = (lsel[0] && !cp) ? lsel[2:1] + 2'd1 : lsel[2:1];
    srch_next.oor     = sel.oor;
  end

  always_ff @(posedge clk) begin
    srch <= srch_next;
    mst  <= srch;
  end

  // blend numerators per channel
  logic [23:0] lc;
  logic [23:0] uc;
  logic        use_lc;
  blend_t      bl_next;
  always_comb begin
    lc     = mst.low_odd ? o_rd : e_rd;
    uc     = mst.low_odd ? e_rd : o_rd;
    use_lc = mst.copy || (mst.hi <= mst.lo);
    bl_next.q   = '0;
    bl_next.oor = mst.oor;
    bl_next.den = (mst.black || use_lc) ? 9'd1 : mst.hi - mst.lo;
    for (int c = 0; c < 3; c++) begin
      if (mst.black)
        bl_next.rem[c] = 17'd0;
      else if (use_lc)
        bl_next.rem[c] = {9'd0, lc[8*c +: 8]};
      else
        bl_next.rem[c] = 17'(lc[8*c +: 8] * (mst.hi - {1'b0, mst.idx})) +
                         17'(uc[8*c +: 8] * ({1'b0, mst.idx} - mst.lo));
    end
  end

  always_ff @(posedge clk) begin
    bl      <= bl_next;
    bdiv[0] <= blend_div2(bl, 6);
    bdiv[1] <= blend_div2(bdiv[0], 4);
    bdiv[2] <= blend_div2(bdiv[1], 2);
    bdiv[3] <= blend_div2(bdiv[2], 0);
    red          <= bdiv[3].oor ? 8'hFF : bdiv[3].q[2];
    green        <= bdiv[3].oor ? 8'hFF : bdiv[3].q[1];
    blue         <= bdiv[3].oor ? 8'hFF : bdiv[3].q[0];
    out_of_range <= bdiv[3].oor;
  end

  assign done = v[PIPE_DEPTH-1];

  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##14 done) else $error("result strobe missing");
  a_white: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> red == 8'hFF && green == 8'hFF && blue == 8'hFF)
    else $error("flagged beat not white");
  a_init_once: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !busy) else $error("busy returned after clearing pass");
  a_no_early_beat: assert property (@(posedge clk) disable iff (rst)
    busy |-> !done) else $error("beat during clearing pass");

endmodule

// ===== tb/tb_gradient_colormap_pixel_unit.sv =====
`timescale 1ns / 100ps

module tb_gradient_colormap_pixel_unit;
  import cmap_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] sample;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        out_of_range;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [53:0] cfg_data;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       flag;
  } pixel_t;

  // local copy of the register file
  logic [53:0] m_pos;
  logic [47:0] m_col_a, m_col_b, m_col_c;
  logic [2:0]  m_count;
  logic [15:0] m_low, m_high;
  logic [1:0]  m_mode;

  pixel_t pixel_q[$];
  int     errors;
  int     idle_cycles;
  bit     gaps_on;

  gradient_colormap_pixel_unit uut (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [8:0] stop_at(int i);
    return m_pos[9*i +: 9];
  endfunction

  function automatic logic [23:0] color_at(int i);
    logic [47:0] w;
    w = (i < 2) ? m_col_a : (i < 4) ? m_col_b : m_col_c;
    return w[24*(i%2) +: 24];
  endfunction

  function automatic int unsigned gray_index(logic [15:0] s);
    int unsigned num, den, q, rm;
    if (!m_mode[0]) return (s > 255) ? 255 : s;
    if (m_high <= m_low || s <= m_low) return 0;
    num = (s - m_low) * 255;
    den = m_high - m_low;
    q = num / den;
    rm = num % den;
    if (2*rm > den || (2*rm == den && q[0])) q++;
    return (q > 255) ? 255 : q;
  endfunction

  function automatic pixel_t map_pixel(logic [15:0] s);
    pixel_t p;
    int unsigned n, i, idx, lo, hi, lc, uc;
    logic [23:0] rgb;
    idx = gray_index(s);
    n = (m_count > 6) ? 6 : m_count;
    if (n == 0) rgb = 24'h0;
    else if (n == 1) rgb = color_at(0);
    else begin
      for (i = 0; i < n; i++)
        if (stop_at(i) >= idx) break;
      if (i == 0) rgb = color_at(0);
      else if (i == n) rgb = color_at(n-1);
      else begin
        lo = stop_at(i-1);
        hi = stop_at(i);
        for (int c = 0; c < 3; c++) begin
          lc = color_at(i-1) >> (8*c) & 8'hFF;
          uc = color_at(i) >> (8*c) & 8'hFF;
          if (hi <= lo || idx < lo || idx > hi) rgb[8*c +: 8] = 8'(lc);
          else rgb[8*c +: 8] = 8'((lc*(hi-idx) + uc*(idx-lo)) / (hi-lo));
        end
      end
    end
    p.flag = 1'b0;
    if (m_mode[1] && (s < m_low || s > m_high)) begin
      rgb = 24'hFFFFFF;
      p.flag = 1'b1;
    end
    {p.r, p.g, p.b} = rgb;
    return p;
  endfunction

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_sample(logic [15:0] s);
    cfg_valid <= 1'b0;
    idle_burst();
    start  <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_q.push_back(map_pixel(s));
  endtask

  task automatic drain();
    if (start) start <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [53:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_POSITIONS: m_pos   = val;
      REG_COLORS_A:  m_col_a = val[47:0];
      REG_COLORS_B:  m_col_b = val[47:0];
      REG_COLORS_C:  m_col_c = val[47:0];
      REG_COUNT:     m_count = val[2:0];
      REG_LOW:       m_low   = val[15:0];
      REG_HIGH:      m_high  = val[15:0];
      REG_MODE:      m_mode  = val[1:0];
      default: ;
    endcase
  endtask

  function automatic logic [53:0] sorted_stops();
    logic [53:0] v;
    int unsigned p;
    p = 0;
    for (int i = 0; i < 6; i++) begin
      p = p + $urandom_range(0, 70);
      v[9*i +: 9] = 9'((p > 511) ? 511 : p);
    end
    return v;
  endfunction

  task automatic random_config();
    logic [15:0] a, b;
    if ($urandom_range(0, 4) == 0)
      write_reg(REG_POSITIONS, 54'({$urandom, $urandom}));
    else
      write_reg(REG_POSITIONS, sorted_stops());
    write_reg(REG_COLORS_A, 54'({$urandom, $urandom}));
    write_reg(REG_COLORS_B, 54'({$urandom, $urandom}));
    write_reg(REG_COLORS_C, 54'({$urandom, $urandom}));
    write_reg(REG_COUNT, 54'($urandom_range(0, 7)));
    a = 16'($urandom);
    b = 16'($urandom);
    if ($urandom_range(0, 5) != 0 && a > b) {a, b} = {b, a};
    write_reg(REG_LOW, 54'(a));
    write_reg(REG_HIGH, 54'(b));
    write_reg(REG_MODE, 54'($urandom_range(0, 3)));
  endtask

  task automatic random_sample();
    logic [15:0] s;
    case ($urandom_range(0, 3))
      0: s = 16'($urandom_range(0, 300));
      1: s = 16'($urandom_range(m_low, m_high > m_low ? m_high : m_low));
      2: s = 16'($urandom);
      default: s = 16'(m_low + $urandom_range(0, 2) - 1);
    endcase
    send_sample(s);
  endtask

  task automatic test_reset_jet();
    foreach (m_pos[i]) ;
    for (int s = 0; s <= 256; s += 32) send_sample(16'(s));
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h00FF);
  endtask

  task automatic test_special_cases();
    drain();
    write_reg(REG_MODE, 54'(2'b11));
    write_reg(REG_LOW, 54'(16'd1000));
    write_reg(REG_HIGH, 54'(16'd3000));
    send_sample(16'd0);
    send_sample(16'd999);
    send_sample(16'd1000);
    send_sample(16'd2000);
    send_sample(16'd3000);
    send_sample(16'd3001);
    drain();
    // empty range
    write_reg(REG_MODE, 54'(2'b01));
    write_reg(REG_HIGH, 54'(16'd1000));
    send_sample(16'd1500);
    send_sample(16'hFFFF);
    drain();
    write_reg(REG_COUNT, 54'(3'd0));
    send_sample(16'd77);
    drain();
    write_reg(REG_COUNT, 54'(3'd1));
    send_sample(16'd200);
    drain();
    write_reg(REG_COUNT, 54'(3'd7));
    write_reg(REG_POSITIONS, {9'd40, 9'd40, 9'd200, 9'd100, 9'd100, 9'd20});
    write_reg(REG_MODE, 54'(2'b00));
    for (int s = 0; s < 256; s += 37) send_sample(16'(s));
    send_sample(16'd100);
    drain();
  endtask

  task automatic test_random(int n_sets, int per_set);
    for (int k = 0; k < n_sets; k++) begin
      drain();
      random_config();
      repeat (per_set) random_sample();
    end
  endtask

  task automatic test_extremes();
    drain();
    write_reg(REG_POSITIONS, '1);
    write_reg(REG_COLORS_A, '1);
    write_reg(REG_COLORS_B, '0);
    write_reg(REG_COLORS_C, '1);
    write_reg(REG_LOW, 54'(16'd0));
    write_reg(REG_HIGH, 54'(16'hFFFF));
    write_reg(REG_MODE, 54'(2'b11));
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain();
    write_reg(REG_POSITIONS, '0);
    write_reg(REG_COLORS_A, 54'(48'h0000FF_FFFF00));
    write_reg(REG_COLORS_B, '0);
    write_reg(REG_COLORS_C, '0);
    send_sample(16'h0000);
    send_sample(16'h8000);
  endtask

  // result check: done strobes for one cycle, no back-pressure
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected beat r=%h g=%h b=%h oor=%b", $time,
                 red, green, blue, out_of_range);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (red !== want.r) begin
          $display("%0t: red exp %h got %h", $time, want.r, red);
          errors++;
        end
        if (green !== want.g) begin
          $display("%0t: green exp %h got %h", $time, want.g, green);
          errors++;
        end
        if (blue !== want.b) begin
          $display("%0t: blue exp %h got %h", $time, want.b, blue);
          errors++;
        end
        if (out_of_range !== want.flag) begin
          $display("%0t: out_of_range exp %b got %b", $time, want.flag, out_of_range);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("gradient_colormap_pixel_unit verification failed");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    idle_cycles = 0;
    gaps_on     = 1'b1;
    rst         = 1'b1;
    start       = 1'b0;
    sample      = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_POSITIONS;
    cfg_data    = '0;
    m_pos       = POSITIONS_RST;
    m_col_a     = {ODD_RST[0], EVEN_RST[0]};
    m_col_b     = {ODD_RST[1], EVEN_RST[1]};
    m_col_c     = {ODD_RST[2], EVEN_RST[2]};
    m_count     = COUNT_RST;
    m_low       = LOW_RST;
    m_high      = HIGH_RST;
    m_mode      = MODE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_jet();
    test_special_cases();
    test_extremes();
    test_random(24, 55);
    // last stretch runs back to back
    gaps_on = 1'b0;
    test_random(6, 50);
    drain();
    if (errors == 0) $display("gradient_colormap_pixel_unit verification clean");
    else $display("gradient_colormap_pixel_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cmap_pkg.sv
rtl/gradient_colormap_pixel_unit.sv
tb/tb_gradient_colormap_pixel_unit.sv
